@@ sv/pbb_pkg.sv @@
// Package: shared constants and types for the pixel block binning block.
package pbb_pkg;

  // Default parameter values
  localparam int DEF_MAX_OUT_WIDTH = 1024;
  localparam int DEF_MAX_BIN       = 16;
  localparam int DEF_PIXEL_BITS    = 16;

  // Fixed field widths of the channels and registers
  localparam int PIXEL_FIELD_W = 16;
  localparam int VALUE_W       = 16;
  localparam int OUT_COL_W     = 10;
  localparam int OUT_ROW_W     = 10;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int FRAME_W       = 16;

  // Binned lines per frame are limited independently of the parameters
  localparam int OUT_HEIGHT_LIMIT = 1024;
  localparam int OH_W             = $clog2(OUT_HEIGHT_LIMIT + 1);
  localparam int SAT_VALUE        = 65535;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BIN_WIDTH   = 3'd0,
    CFG_BIN_HEIGHT  = 3'd1,
    CFG_OUT_WIDTH   = 3'd2,
    CFG_OUT_HEIGHT  = 3'd3,
    CFG_FRAME_COUNT = 3'd4
  } cfg_idx_t;

endpackage

@@ sv/pbb_if.sv @@
// Interfaces: pixel input channel and binned result channel.
interface pbb_pix_if
  import pbb_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [PIXEL_FIELD_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface pbb_res_if
  import pbb_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [VALUE_W-1:0]   binned_value;
  logic [OUT_COL_W-1:0] out_col;
  logic [OUT_ROW_W-1:0] out_row;
  logic                 last_of_frame;
  logic                 last_of_sequence;

  modport source (output valid, output binned_value, output out_col, output out_row,
                  output last_of_frame, output last_of_sequence, input ready);
  modport sink   (input valid, input binned_value, input out_col, input out_row,
                  input last_of_frame, input last_of_sequence, output ready);
endinterface

@@ sv/pixel_block_binning.sv @@
// Top level: sum binning of a raster pixel stream through a line store of column sums.
//
// Takes one pixel per clock when ready, in raster order (bin_width*out_width pixels
// per line, bin_height*out_height lines per frame) and returns one saturated 16-bit
// sum per bin_width x bin_height block. Horizontal sums are kept in a register; the
// partial column sums live in a single-port-write, single-port-read line store of
// MAX_OUT_WIDTH words, read when a line's last pixel of a block arrives and written
// back by the second stage. A read that meets the write of the same column in the same
// cycle (single-column frames) is forwarded, so the rate stays at one pixel per clock.
// A result passes the second stage and then the output register, which holds it; the
// input keeps flowing while it waits to be taken, until the next completed block
// reaches the store stage and holds the input back. The line store needs no clearing:
// the first line of each block row overwrites each entry. Registers are written by the
// user via the cfg port only while no pixel is in flight; the block does not check it.
module pixel_block_binning
  import pbb_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int MAX_BIN       = DEF_MAX_BIN,
  parameter int PIXEL_BITS    = DEF_PIXEL_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  pbb_pix_if.sink                in_ch,
  pbb_res_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SUB_W  = $clog2(MAX_BIN);
  localparam int BIN_W  = $clog2(MAX_BIN + 1);
  localparam int COL_W  = $clog2(MAX_OUT_WIDTH);
  localparam int OW_W   = $clog2(MAX_OUT_WIDTH + 1);
  localparam int HACC_W = PIXEL_BITS + SUB_W;
  localparam int SUM_W  = PIXEL_BITS + 2 * SUB_W;
  localparam int CMP_W  = (SUM_W > VALUE_W) ? SUM_W : VALUE_W;
  localparam int OW_RST = (MAX_OUT_WIDTH < 1024) ? MAX_OUT_WIDTH : 1024;

  // Effective (clamped) register values
  logic [BIN_W-1:0]   bw_r, bh_r;
  logic [OW_W-1:0]    ow_r;
  logic [OH_W-1:0]    oh_r;
  logic [FRAME_W-1:0] fc_r;

  // Position state
  logic [HACC_W-1:0]    hacc_r;
  logic [SUB_W-1:0]     sub_col_r, sub_row_r;
  logic [COL_W-1:0]     col_r;
  logic [OUT_ROW_W-1:0] row_r;
  logic [FRAME_W-1:0]   frame_r;

  // Second stage: read-modify-write of the line store
  logic                 s1_valid_r;
  logic [HACC_W-1:0]    s1_h_r;
  logic [COL_W-1:0]     s1_col_r;
  logic                 s1_first_r;
  logic                 s1_emit_r;
  logic [OUT_ROW_W-1:0] s1_row_r;
  logic                 s1_lof_r, s1_los_r;

  // Line store and its read side
  logic [SUM_W-1:0] store [MAX_OUT_WIDTH];
  logic [SUM_W-1:0] rdata_r;
  logic             fwd_hit_r;
  logic [SUM_W-1:0] fwd_data_r;

  // Output register
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic                 out_lof_r, out_los_r;

  // Clamped values of the incoming configuration word
  logic [BIN_W-1:0]   cfg_bin;
  logic [OW_W-1:0]    cfg_ow;
  logic [OH_W-1:0]    cfg_oh;
  logic [FRAME_W-1:0] cfg_fc;

  always_comb begin
    if (cfg_data[4:0] == 5'd0) begin
      cfg_bin = BIN_W'(1);
    end else if (int'(cfg_data[4:0]) > MAX_BIN) begin
      cfg_bin = BIN_W'(MAX_BIN);
    end else begin
      cfg_bin = BIN_W'(cfg_data[4:0]);
    end
    if (cfg_data[10:0] == 11'd0) begin
      cfg_ow = OW_W'(1);
    end else if (int'(cfg_data[10:0]) > MAX_OUT_WIDTH) begin
      cfg_ow = OW_W'(MAX_OUT_WIDTH);
    end else begin
      cfg_ow = OW_W'(cfg_data[10:0]);
    end
    if (cfg_data[10:0] == 11'd0) begin
      cfg_oh = OH_W'(1);
    end else if (int'(cfg_data[10:0]) > OUT_HEIGHT_LIMIT) begin
      cfg_oh = OH_W'(OUT_HEIGHT_LIMIT);
    end else begin
      cfg_oh = OH_W'(cfg_data[10:0]);
    end
    cfg_fc = (cfg_data == '0) ? FRAME_W'(1) : cfg_data;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= BIN_W'(1);
      bh_r <= BIN_W'(1);
      ow_r <= OW_W'(OW_RST);
      oh_r <= OH_W'(OUT_HEIGHT_LIMIT);
      fc_r <= FRAME_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIN_WIDTH:   bw_r <= cfg_bin;
        CFG_BIN_HEIGHT:  bh_r <= cfg_bin;
        CFG_OUT_WIDTH:   ow_r <= cfg_ow;
        CFG_OUT_HEIGHT:  oh_r <= cfg_oh;
        CFG_FRAME_COUNT: fc_r <= cfg_fc;
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_adv, in_acc, col_end;
  logic emit, col_last, row_last, frame_last;
  logic [HACC_W-1:0] h;

  assign s1_adv = s1_valid_r && (!s1_emit_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc = in_ch.valid && in_ch.ready;

  // Position decode of the current word
  always_comb begin
    h          = hacc_r + HACC_W'(in_ch.pixel[PIXEL_BITS-1:0]);
    col_end    = !((BIN_W'(sub_col_r) + BIN_W'(1)) < bw_r);
    emit       = (BIN_W'(sub_row_r) + BIN_W'(1)) >= bh_r;
    col_last   = (OW_W'(col_r) + OW_W'(1)) >= ow_r;
    row_last   = (OH_W'(row_r) + OH_W'(1)) >= oh_r;
    frame_last = ({1'b0, frame_r} + 17'd1) >= {1'b0, fc_r};
  end

  // Position counters and horizontal accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hacc_r    <= '0;
      sub_col_r <= '0;
      sub_row_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      frame_r   <= '0;
    end else if (in_acc) begin
      if (!col_end) begin
        hacc_r    <= h;
        sub_col_r <= sub_col_r + SUB_W'(1);
      end else begin
        hacc_r    <= '0;
        sub_col_r <= '0;
        if (!col_last) begin
          col_r <= col_r + COL_W'(1);
        end else begin
          col_r <= '0;
          if (!emit) begin
            sub_row_r <= sub_row_r + SUB_W'(1);
          end else begin
            sub_row_r <= '0;
            if (!row_last) begin
              row_r <= row_r + OUT_ROW_W'(1);
            end else begin
              row_r   <= '0;
              frame_r <= frame_last ? '0 : frame_r + FRAME_W'(1);
            end
          end
        end
      end
    end
  end

  // Stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc && col_end) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc && col_end) begin
      s1_h_r     <= h;
      s1_col_r   <= col_r;
      s1_first_r <= (sub_row_r == '0);
      s1_emit_r  <= emit;
      s1_row_r   <= row_r;
      s1_lof_r   <= col_last && row_last;
      s1_los_r   <= col_last && row_last && frame_last;
    end
  end

  // Column sum update
  logic             rd_en, wr_en;
  logic [SUM_W-1:0] old_sum, new_sum;

  assign rd_en   = in_acc && col_end;
  assign wr_en   = s1_adv;
  assign old_sum = fwd_hit_r ? fwd_data_r : rdata_r;
  assign new_sum = s1_first_r ? SUM_W'(s1_h_r) : old_sum + SUM_W'(s1_h_r);

  // Line store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[s1_col_r] <= new_sum;
    end
    if (rd_en) begin
      rdata_r <= store[col_r];
    end
  end

  // Same-column write in the read cycle is taken from the write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= new_sum;
    end
  end

  // Saturation
  logic [CMP_W-1:0]   sum_ext;
  logic [VALUE_W-1:0] sat_value;

  always_comb begin
    sum_ext = CMP_W'(new_sum);
    if (sum_ext > CMP_W'(SAT_VALUE)) begin
      sat_value = VALUE_W'(SAT_VALUE);
    end else begin
      sat_value = VALUE_W'(sum_ext);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_value_r <= sat_value;
      out_col_r   <= OUT_COL_W'(s1_col_r);
      out_row_r   <= s1_row_r;
      out_lof_r   <= s1_lof_r;
      out_los_r   <= s1_los_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.binned_value     = out_value_r;
  assign out_ch.out_col          = out_col_r;
  assign out_ch.out_row          = out_row_r;
  assign out_ch.last_of_frame    = out_lof_r;
  assign out_ch.last_of_sequence = out_los_r;

endmodule

@@ test/tb_pixel_block_binning.sv @@
// Testbench for pixel_block_binning: directed and random binning runs checked by a scoreboard.
import pbb_pkg::*;

// One binned output word as the result channel carries it
typedef struct packed {
  logic [VALUE_W-1:0]   value;
  logic [OUT_COL_W-1:0] col;
  logic [OUT_ROW_W-1:0] row;
  logic                 frame_end;
  logic                 seq_end;
} bin_result_t;

// Size register as the block sees it: zero counts as one, oversize is clipped
function automatic int unsigned size_of(int unsigned v, int unsigned hi);
  if (v == 0) return 1;
  return (v > hi) ? hi : v;
endfunction

// Block-sum predictor and queue of expected binned words
class bin_scoreboard;
  logic [4:0]         bin_w, bin_h;
  logic [10:0]        out_w, out_h;
  logic [FRAME_W-1:0] frames;
  int unsigned        col_sum [DEF_MAX_OUT_WIDTH];
  int unsigned        h_acc, sub_col, sub_row, col_idx, row_idx, frame_idx;
  bin_result_t        pending [$];
  int                 errors;

  function new();
    bin_w = 5'd1;
    bin_h = 5'd1;
    out_w = 11'd1024;
    out_h = 11'd1024;
    frames = 16'd1;
    foreach (col_sum[i]) col_sum[i] = 0;
    h_acc = 0;
    sub_col = 0;
    sub_row = 0;
    col_idx = 0;
    row_idx = 0;
    frame_idx = 0;
    errors = 0;
  endfunction

  task report(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_BIN_WIDTH:   bin_w = d[4:0];
      CFG_BIN_HEIGHT:  bin_h = d[4:0];
      CFG_OUT_WIDTH:   out_w = d[10:0];
      CFG_OUT_HEIGHT:  out_h = d[10:0];
      CFG_FRAME_COUNT: frames = d[FRAME_W-1:0];
      default: ;
    endcase
  endfunction

  // Fold one accepted pixel into the sums; queue a word when a block completes
  function void note_pixel(logic [PIXEL_FIELD_W-1:0] pix);
    int unsigned bw, bh, ow, oh, fc, h, s, col;
    bit          col_last, row_last, frame_last, emit;
    bin_result_t want;
    bw = size_of(bin_w, DEF_MAX_BIN);
    bh = size_of(bin_h, DEF_MAX_BIN);
    ow = size_of(out_w, DEF_MAX_OUT_WIDTH);
    oh = size_of(out_h, OUT_HEIGHT_LIMIT);
    fc = size_of(frames, (1 << FRAME_W) - 1);
    h = h_acc + pix;
    if (sub_col + 1 < bw) begin
      h_acc = h;
      sub_col++;
      return;
    end
    h_acc = 0;
    sub_col = 0;

    // column sum: first line of a block row starts fresh
    col = col_idx % DEF_MAX_OUT_WIDTH;
    s = (sub_row == 0) ? h : col_sum[col] + h;
    col_sum[col] = s;

    emit       = (sub_row + 1 >= bh);
    col_last   = (col_idx + 1 >= ow);
    row_last   = (row_idx + 1 >= oh);
    frame_last = (frame_idx + 1 >= fc);

    if (emit) begin
      want.value     = (s > SAT_VALUE) ? VALUE_W'(SAT_VALUE) : VALUE_W'(s);
      want.col       = col_idx[OUT_COL_W-1:0];
      want.row       = row_idx[OUT_ROW_W-1:0];
      want.frame_end = col_last && row_last;
      want.seq_end   = col_last && row_last && frame_last;
      pending.push_back(want);
    end

    // position counters wrap once they reach or pass their limit
    if (!col_last) begin
      col_idx++;
    end else begin
      col_idx = 0;
      if (!emit) begin
        sub_row++;
      end else begin
        sub_row = 0;
        if (!row_last) begin
          row_idx++;
        end else begin
          row_idx = 0;
          frame_idx = frame_last ? 0 : frame_idx + 1;
        end
      end
    end
  endfunction

  task check_result(bin_result_t got);
    bin_result_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected word value %0d col %0d row %0d",
                       got.value, got.col, got.row));
      return;
    end
    want = pending.pop_front();
    if (got.value !== want.value)
      report($sformatf("value %0d, want %0d (col %0d row %0d)",
                       got.value, want.value, want.col, want.row));
    if (got.col !== want.col)
      report($sformatf("out_col %0d, want %0d", got.col, want.col));
    if (got.row !== want.row)
      report($sformatf("out_row %0d, want %0d", got.row, want.row));
    if (got.frame_end !== want.frame_end)
      report($sformatf("last_of_frame %b, want %b (col %0d row %0d)",
                       got.frame_end, want.frame_end, want.col, want.row));
    if (got.seq_end !== want.seq_end)
      report($sformatf("last_of_sequence %b, want %b (col %0d row %0d)",
                       got.seq_end, want.seq_end, want.col, want.row));
  endtask
endclass

module tb_pixel_block_binning;
  localparam int LAT_PAUSE      = 8;
  localparam int END_PAUSE      = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1250;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int unsigned   send_idle;
  int unsigned   recv_stall;
  int unsigned   quiet_cycles;
  int unsigned   pixels_sent;
  int            phase;
  bin_scoreboard sb;
  bin_result_t   seen;

  pbb_pix_if pix_ch ();
  pbb_res_if res_ch ();

  pixel_block_binning u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side backpressure
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Monitor: predict on accepted pixels, check accepted words, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (pix_ch.valid && pix_ch.ready) sb.note_pixel(pix_ch.pixel);
      if (res_ch.valid && res_ch.ready) begin
        seen.value     = res_ch.binned_value;
        seen.col       = res_ch.out_col;
        seen.row       = res_ch.out_row;
        seen.frame_end = res_ch.last_of_frame;
        seen.seq_end   = res_ch.last_of_sequence;
        sb.check_result(seen);
      end
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("pixel_block_binning test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [PIXEL_FIELD_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_FIELD_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_bin();
    case ($urandom_range(15))
      0:       return 0;
      1:       return $urandom_range(31, 17);
      2:       return 16;
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  // Idling of the random stream: four equal stretches of the word budget
  task automatic set_idle_mode(input int unsigned sent);
    case ((sent * 4 / RANDOM_ITEMS) % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 69; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 69; end
      default: begin send_idle = 23; recv_stall = 23; end
    endcase
  endtask

  // One pixel word, with random idle cycles ahead of it
  task automatic send_pixel(input logic [PIXEL_FIELD_W-1:0] p);
    while ($urandom_range(99) < send_idle) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Stop sending and let every expected word come out, then let the pipe settle
  task automatic hold_until_drained();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LAT_PAUSE) @(posedge clk);
  endtask

  // Register write; the enable is left high so back-to-back writes stay clean
  task automatic put_reg(input cfg_idx_t idx, input int unsigned v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(v);
    @(posedge clk);
    sb.write_reg(idx, CFG_DATA_W'(v));
  endtask

  task automatic load_regs(input int unsigned bw, input int unsigned bh, input int unsigned ow,
                           input int unsigned oh, input int unsigned fc);
    put_reg(CFG_BIN_WIDTH, bw);
    put_reg(CFG_BIN_HEIGHT, bh);
    put_reg(CFG_OUT_WIDTH, ow);
    put_reg(CFG_OUT_HEIGHT, oh);
    put_reg(CFG_FRAME_COUNT, fc);
    cfg_we <= 1'b0;
  endtask

  // One random setting, fed whole block rows so each phase ends on a block-row boundary
  task automatic run_random_phase(input int phase_no);
    int unsigned bw_v, bh_v, ow_v, oh_v, fc_v, block_row, rows, n, half;
    bit          squeeze;

    if (phase_no == 0) begin
      // largest block: both bin sizes oversize
      bw_v = 31;
      bh_v = 20;
      ow_v = 1;
    end else if (phase_no == 1) begin
      // widest line: out_width at or beyond its maximum
      bw_v = 1;
      bh_v = 0;
      ow_v = $urandom_range(2047, 1024);
    end else begin
      bw_v = pick_bin();
      bh_v = pick_bin();
      if (size_of(bw_v, DEF_MAX_BIN) * size_of(bh_v, DEF_MAX_BIN) > 16) begin
        ow_v = $urandom_range(1, 2);
      end else begin
        case ($urandom_range(15))
          0:       ow_v = 0;
          1:       ow_v = $urandom_range(10, 40);
          default: ow_v = $urandom_range(1, 8);
        endcase
      end
    end
    case ($urandom_range(7))
      0:       oh_v = 0;
      1:       oh_v = $urandom_range(2047);
      default: oh_v = $urandom_range(1, 4);
    endcase
    case ($urandom_range(7))
      0:       fc_v = 0;
      1:       fc_v = $urandom_range(65535);
      default: fc_v = $urandom_range(1, 3);
    endcase

    load_regs(bw_v, bh_v, ow_v, oh_v, fc_v);
    block_row = size_of(bw_v, DEF_MAX_BIN) * size_of(bh_v, DEF_MAX_BIN)
              * size_of(ow_v, DEF_MAX_OUT_WIDTH);
    rows = 1 + $urandom_range(0, 160 / block_row);
    n = rows * block_row;
    half = n / 2;
    squeeze = (phase_no % 6 == 1);
    for (int unsigned i = 0; i < n; i++) begin
      set_idle_mode(pixels_sent + i);
      if (squeeze && i == half) hold_until_drained();
      send_pixel(pick_pixel());
    end
    pixels_sent += n;
    hold_until_drained();
  endtask

  initial begin
    sb = new();
    send_idle = 0;
    recv_stall = 0;
    pixels_sent = 0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_BIN_WIDTH;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 1x1 bins, pixel extremes and alternating bits
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hAAAA);
    send_pixel(16'h5555);
    hold_until_drained();

    // mid-line write: column counter already past the new width wraps
    load_regs(1, 1, 4, 2, 1);
    send_pixel(pick_pixel());
    for (int i = 0; i < 4; i++) send_pixel(pick_pixel());
    hold_until_drained();

    // zero sizes act as one; 2x2 of full-scale pixels saturates
    load_regs(2, 2, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_pixel(16'hFFFF);
    hold_until_drained();

    // oversize bin height, single column: column sum reread every line
    load_regs(1, 31, 1, 1, 2);
    for (int i = 0; i < 16; i++) send_pixel(pick_pixel());
    hold_until_drained();

    // frame count lowered to no more than the frame counter: sequence ends at once
    load_regs(1, 1, 1, 1, 1);
    send_pixel(pick_pixel());
    hold_until_drained();

    // random settings and pixels
    phase = 0;
    while (pixels_sent < RANDOM_ITEMS) begin
      run_random_phase(phase);
      phase++;
    end

    send_idle = 0;
    recv_stall = 0;
    hold_until_drained();
    repeat (END_PAUSE) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("pixel_block_binning test passed");
    end else begin
      $display("pixel_block_binning test failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/pbb_pkg.sv
sv/pbb_if.sv
sv/pixel_block_binning.sv
test/tb_pixel_block_binning.sv
